/* rtl/ube_pkg.sv */
// ----------------------------------------------------------------------------
// ube_pkg: serial flash bootloader engine package
// Types, protocol codes and sizes shared by the engine and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package ube_pkg;

  localparam int FlashBytesDef = 32768;
  localparam int PageBytesDef  = 1024;
  localparam int BufBytes      = 258;
  localparam int BufAw         = 9;
  localparam int WideW         = 17;
  localparam int QDepth        = 16;

  localparam logic [7:0] AckByte  = 8'h79;
  localparam logic [7:0] NackByte = 8'h1F;
  localparam logic [7:0] CmdInit  = 8'h7F;
  localparam logic [7:0] CmdGet   = 8'h00;
  localparam logic [7:0] CmdGetVer = 8'h01;
  localparam logic [7:0] CmdGetId = 8'h02;
  localparam logic [7:0] CmdRead  = 8'h11;
  localparam logic [7:0] CmdGo    = 8'h21;
  localparam logic [7:0] CmdWrite = 8'h31;
  localparam logic [7:0] CmdErase = 8'h43;
  localparam logic [7:0] GetCount = 8'h07;
  localparam logic [7:0] ByteFf   = 8'hFF;
  localparam logic [7:0] ByteZero = 8'h00;

  localparam logic [1:0] RegVersion   = 2'd0;
  localparam logic [1:0] RegProductId = 2'd1;
  localparam logic [1:0] RegProtPages = 2'd2;
  localparam logic [1:0] RegTotPages  = 2'd3;

  typedef enum logic [3:0] {
    PhIdle, PhCheck, PhAddr, PhRlen, PhRchk, PhWlen, PhWdata, PhWsum,
    PhElen, PhEfull, PhElist, PhEsum
  } ube_phase_e;

  typedef enum logic [3:0] {
    StClear, StIdle, StTxRd, StTxOut, StReply, StWcRd, StWcWr,
    StElRd, StElDat, StEPage, StEWipe, StENext
  } ube_state_e;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } ube_in_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  tx_byte;
    logic [15:0] jump_address;
  } ube_out_t;

endpackage

`default_nettype wire

/* rtl/ube_ram.sv */
// ----------------------------------------------------------------------------
// ube_ram: generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ube_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/uart_flash_bootloader_engine.sv */
// A check byte that starts get, get-version or get-id then pushes its reply bytes.
// A transmit slot is held while the output stalls; a streamed byte is read from flash first.
// Write commit: each buffered byte is ANDed into the flash byte at its address.
// Erase: each page wiped is filled with 0xFF. After reset the flash RAM is filled with
// 0xFF, one byte per cycle, and no item is accepted until then. Control registers take
// resets; the result, page base, offset, queue storage and output data do not.
// ----------------------------------------------------------------------------
// uart_flash_bootloader_engine: serial flash bootloader slave
// Command parser, reply queue, flash store and page buffer in RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_flash_bootloader_engine
  import ube_pkg::*;
#(
  parameter int FLASH_BYTES = FlashBytesDef,
  parameter int PAGE_BYTES  = PageBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire ube_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output ube_out_t         out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int Aw      = $clog2(FLASH_BYTES);
  localparam int Ow      = $clog2(PAGE_BYTES);
  localparam int PageLim = FLASH_BYTES / PAGE_BYTES;

  ube_state_e st_q, st_d;
  ube_phase_e phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d, sum_q, sum_d, pg_q, pg_d;
  logic [15:0] ta_q, ta_d;
  logic [8:0]  bc_q, bc_d, pend_q, pend_d, stream_q, stream_d, wi_q, wi_d;
  logic        jump_q, jump_d, full_q, full_d, txin_q, txin_d;
  logic [3:0]  rep_q, rep_d, qhead_q;
  logic [4:0]  qcnt_q;
  logic [7:0]  qmem_q [QDepth];
  logic        push_en, pop_en;
  logic [7:0]  push_byte;
  logic [Aw-1:0] clr_q, clr_d, base_q, base_d;
  logic [Ow-1:0] off_q, off_d;
  ube_out_t    res_q, res_d, out_q;
  logic        out_valid_q;
  logic [7:0]  ver_q;
  logic [15:0] pid_q;
  logic [5:0]  prot_q, tot_q;

  logic          fl_we;
  logic [Aw-1:0] fl_waddr, fl_raddr;
  logic [7:0]    fl_wdata, fl_rdata;
  logic          bf_we;
  logic [BufAw-1:0] bf_waddr, bf_raddr;
  logic [7:0]    bf_wdata, bf_rdata;

  logic        acc;
  logic [7:0]  b;
  logic [WideW-1:0] wa, prod;
  logic [8:0]  pend_n;
  logic        out_free;

  ube_ram #(.Width(8), .Depth(FLASH_BYTES)) u_flash (
    .clk_i, .we_i(fl_we), .waddr_i(fl_waddr), .wdata_i(fl_wdata),
    .raddr_i(fl_raddr), .rdata_o(fl_rdata)
  );

  ube_ram #(.Width(8), .Depth(BufBytes)) u_buf (
    .clk_i, .we_i(bf_we), .waddr_i(bf_waddr), .wdata_i(bf_wdata),
    .raddr_i(bf_raddr), .rdata_o(bf_rdata)
  );

  function automatic logic [7:0] reply_at(logic [7:0] cmd, logic [3:0] idx,
                                          logic [7:0] ver, logic [15:0] pid);
    logic [7:0] r;
    r = AckByte;
    if (cmd == CmdGet) begin
      case (idx)
        4'd0: r = GetCount;
        4'd1: r = ver;
        4'd2: r = CmdGet;
        4'd3: r = CmdGetVer;
        4'd4: r = CmdGetId;
        4'd5: r = CmdRead;
        4'd6: r = CmdGo;
        4'd7: r = CmdWrite;
        4'd8: r = CmdErase;
        default: r = AckByte;
      endcase
    end else if (cmd == CmdGetVer) begin
      case (idx)
        4'd0: r = ver;
        4'd1: r = ByteZero;
        4'd2: r = ByteZero;
        default: r = AckByte;
      endcase
    end else begin
      case (idx)
        4'd0: r = 8'h01;
        4'd1: r = pid[15:8];
        4'd2: r = pid[7:0];
        default: r = AckByte;
      endcase
    end
    return r;
  endfunction

  assign in_stall_o  = (st_q != StIdle);
  assign acc         = in_valid_i && (st_q == StIdle);
  assign b           = in_data_i.rx_byte;
  assign wa          = WideW'(ta_q) + WideW'(wi_q);
  assign prod        = WideW'(pg_q) * WideW'(PAGE_BYTES);
  assign pend_n      = (pend_q != 9'd0) ? pend_q - 9'd1 : 9'd0;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;

  always_comb begin
    st_d = st_q; phase_d = phase_q; cmd_d = cmd_q; sum_d = sum_q; pg_d = pg_q;
    ta_d = ta_q; bc_d = bc_q; pend_d = pend_q; stream_d = stream_q; wi_d = wi_q;
    jump_d = jump_q; full_d = full_q; txin_d = txin_q; rep_d = rep_q;
    clr_d = clr_q; base_d = base_q; off_d = off_q; res_d = res_q;
    push_en = 1'b0; push_byte = AckByte; pop_en = 1'b0;
    fl_we = 1'b0; fl_waddr = base_q + Aw'(off_q); fl_wdata = ByteFf;
    fl_raddr = wa[Aw-1:0];
    bf_we = 1'b0; bf_waddr = bc_q; bf_wdata = b; bf_raddr = wi_q;

    case (st_q)
      StClear: begin
        fl_we = 1'b1;
        fl_waddr = clr_q;
        clr_d = clr_q + Aw'(1);
        if (clr_q == Aw'(FLASH_BYTES - 1)) st_d = StIdle;
      end
      StIdle: begin
        if (acc && in_data_i.func) begin
          if (qcnt_q != 5'd0) begin
            res_d = '{out_kind: 1'b0, tx_byte: qmem_q[qhead_q], jump_address: 16'd0};
            pop_en = 1'b1;
            st_d = StTxOut;
          end else if (stream_q != 9'd0) begin
            fl_raddr = ta_q[Aw-1:0];
            txin_d = (WideW'(ta_q) < WideW'(FLASH_BYTES));
            ta_d = ta_q + 16'd1;
            stream_d = stream_q - 9'd1;
            st_d = StTxRd;
          end else if (jump_q) begin
            jump_d = 1'b0;
            res_d = '{out_kind: 1'b1, tx_byte: 8'd0, jump_address: ta_q};
            st_d = StTxOut;
          end
        end else if (acc && stream_q == 9'd0 && !jump_q) begin
          case (phase_q)
            PhCheck: begin
              if (b == (cmd_q ^ ByteFf)) begin
                push_en = 1'b1;
                phase_d = PhIdle;
                case (cmd_q)
                  CmdGet, CmdGetVer, CmdGetId: begin
                    rep_d = 4'd0;
                    st_d = StReply;
                  end
                  CmdErase: phase_d = PhElen;
                  CmdRead, CmdGo, CmdWrite: begin
                    phase_d = PhAddr;
                    bc_d = 9'd0; sum_d = 8'd0; ta_d = 16'd0;
                  end
                  default: push_byte = NackByte;
                endcase
              end else if (b == CmdInit) begin
                push_en = 1'b1;
                phase_d = PhIdle;
              end else begin
                cmd_d = b;
              end
            end
            PhAddr: begin
              if (bc_q < 9'd4) begin
                sum_d = sum_q ^ b;
                if (bc_q >= 9'd2) ta_d = {ta_q[7:0], b};
                bc_d = bc_q + 9'd1;
              end else if (b != sum_q || WideW'(ta_q) > WideW'(FLASH_BYTES)) begin
                push_en = 1'b1; push_byte = NackByte; phase_d = PhIdle;
              end else begin
                push_en = 1'b1;
                if (cmd_q == CmdRead) phase_d = PhRlen;
                else if (cmd_q == CmdGo) begin
                  jump_d = 1'b1; phase_d = PhIdle;
                end else phase_d = PhWlen;
              end
            end
            PhRlen: begin
              bc_d = {1'b0, b};
              phase_d = PhRchk;
            end
            PhRchk: begin
              push_en = 1'b1;
              phase_d = PhIdle;
              if (bc_q != {1'b0, b ^ ByteFf}) push_byte = NackByte;
              else stream_d = bc_q + 9'd1;
            end
            PhWlen: begin
              sum_d = b;
              pend_d = {1'b0, b} + 9'd1;
              bc_d = 9'd0;
              if (ta_q[0]) begin
                ta_d = ta_q - 16'd1;
                bf_we = 1'b1; bf_waddr = '0; bf_wdata = ByteFf;
                bc_d = 9'd1;
              end
              phase_d = PhWdata;
            end
            PhWdata, PhElist: begin
              if (bc_q < 9'(BufBytes)) begin
                bf_we = 1'b1;
                bc_d = bc_q + 9'd1;
              end
              sum_d = sum_q ^ b;
              pend_d = pend_n;
              if (pend_n == 9'd0) phase_d = (phase_q == PhWdata) ? PhWsum : PhEsum;
            end
            PhWsum: begin
              phase_d = PhIdle;
              if (b != sum_q) begin
                push_en = 1'b1; push_byte = NackByte;
              end else begin
                if (bc_q[0] && bc_q < 9'(BufBytes)) begin
                  bf_we = 1'b1; bf_wdata = ByteFf;
                  bc_d = bc_q + 9'd1;
                end
                wi_d = 9'd0;
                st_d = StWcRd;
              end
            end
            PhElen: begin
              sum_d = b;
              bc_d = 9'd0;
              if (b == ByteFf) phase_d = PhEfull;
              else begin
                pend_d = {1'b0, b} + 9'd1;
                phase_d = PhElist;
              end
            end
            PhEfull: begin
              phase_d = PhIdle;
              if (b != ByteZero) begin
                push_en = 1'b1; push_byte = NackByte;
              end else if (prot_q < tot_q) begin
                pg_d = {2'b0, prot_q}; full_d = 1'b1; st_d = StEPage;
              end else begin
                push_en = 1'b1;
              end
            end
            PhEsum: begin
              phase_d = PhIdle;
              if (b != sum_q) begin
                push_en = 1'b1; push_byte = NackByte;
              end else begin
                wi_d = 9'd0; full_d = 1'b0; st_d = StElRd;
              end
            end
            default: begin
              if (b == CmdInit) push_en = 1'b1;
              else begin
                cmd_d = b; phase_d = PhCheck;
              end
            end
          endcase
        end
      end
      StTxRd: begin
        res_d = '{out_kind: 1'b0, tx_byte: txin_q ? fl_rdata : ByteFf,
                  jump_address: 16'd0};
        st_d = StTxOut;
      end
      StTxOut: begin
        if (out_free) st_d = StIdle;
      end
      StReply: begin
        push_en = 1'b1;
        push_byte = reply_at(cmd_q, rep_q, ver_q, pid_q);
        rep_d = rep_q + 4'd1;
        if (rep_q == ((cmd_q == CmdGet) ? 4'd9 : 4'd3)) st_d = StIdle;
      end
      StWcRd: begin
        if (wi_q < bc_q) st_d = StWcWr;
        else begin
          push_en = 1'b1; st_d = StIdle;
        end
      end
      StWcWr: begin
        if (wa < WideW'(FLASH_BYTES)) begin
          fl_we = 1'b1;
          fl_waddr = wa[Aw-1:0];
          fl_wdata = fl_rdata & bf_rdata;
        end
        wi_d = wi_q + 9'd1;
        st_d = StWcRd;
      end
      StElRd: begin
        if (wi_q < bc_q) st_d = StElDat;
        else begin
          push_en = 1'b1; st_d = StIdle;
        end
      end
      StElDat: begin
        pg_d = bf_rdata;
        wi_d = wi_q + 9'd1;
        st_d = StEPage;
      end
      StEPage: begin
        if (pg_q < {2'b0, tot_q} && 9'(pg_q) < 9'(PageLim)) begin
          base_d = prod[Aw-1:0];
          off_d = '0;
          st_d = StEWipe;
        end else st_d = StENext;
      end
      StEWipe: begin
        fl_we = 1'b1;
        off_d = off_q + Ow'(1);
        if (off_q == Ow'(PAGE_BYTES - 1)) st_d = StENext;
      end
      StENext: begin
        if (!full_q) st_d = StElRd;
        else if ((pg_q + 8'd1) < {2'b0, tot_q}) begin
          pg_d = pg_q + 8'd1; st_d = StEPage;
        end else begin
          push_en = 1'b1; st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; phase_q <= PhIdle; cmd_q <= '0; sum_q <= '0; pg_q <= '0;
      ta_q <= '0; bc_q <= '0; pend_q <= '0; stream_q <= '0; wi_q <= '0;
      jump_q <= 1'b0; full_q <= 1'b0; txin_q <= 1'b0; rep_q <= '0;
      clr_q <= '0; qhead_q <= '0; qcnt_q <= '0; out_valid_q <= 1'b0;
      ver_q <= 8'd16; pid_q <= 16'd1040; prot_q <= 6'd4; tot_q <= 6'd32;
    end else begin
      st_q <= st_d; phase_q <= phase_d; cmd_q <= cmd_d; sum_q <= sum_d;
      pg_q <= pg_d; ta_q <= ta_d; bc_q <= bc_d; pend_q <= pend_d;
      stream_q <= stream_d; wi_q <= wi_d; jump_q <= jump_d; full_q <= full_d;
      txin_q <= txin_d; rep_q <= rep_d; clr_q <= clr_d;
      if (pop_en) begin
        qhead_q <= qhead_q + 4'd1;
        qcnt_q <= qcnt_q - 5'd1;
      end else if (push_en && qcnt_q < 5'(QDepth)) begin
        qcnt_q <= qcnt_q + 5'd1;
      end
      if (st_q == StTxOut && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          RegVersion:   ver_q <= pwdata[7:0];
          RegProductId: pid_q <= pwdata[15:0];
          RegProtPages: prot_q <= pwdata[5:0];
          RegTotPages:  tot_q <= pwdata[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d; base_q <= base_d; off_q <= off_d;
    if (push_en && qcnt_q < 5'(QDepth)) begin
      qmem_q[qhead_q + qcnt_q[3:0]] <= push_byte;
    end
    if (st_q == StTxOut && out_free) out_q <= res_q;
  end

  always_comb begin
    case (paddr[3:2])
      RegVersion:   prdata = {24'd0, ver_q};
      RegProductId: prdata = {16'd0, pid_q};
      RegProtPages: prdata = {26'd0, prot_q};
      RegTotPages:  prdata = {26'd0, tot_q};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

/* bench/tb_uart_flash_bootloader_engine.sv */
// ----------------------------------------------------------------------------
// tb_uart_flash_bootloader_engine: bootloader engine testbench
// Drives received bytes and transmit slots into the engine and keeps a
// behavioral copy of the parser, reply queue and flash store. Every transfer
// out of the engine is checked against that copy or, in the directed table run
// first, against a fixed byte. Random good and broken command sequences follow
// under four register settings, with random idle gaps and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_uart_flash_bootloader_engine
  import ube_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FLASH     = FlashBytesDef;
  localparam int PAGE      = PageBytesDef;
  localparam int WDOG_MAX  = 200000;
  localparam int SETTLE    = 40000;
  localparam int PER_PHASE = 300;

  localparam int RowPred  = 0;
  localparam int RowNone  = 1;
  localparam int RowByte  = 2;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  ube_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  ube_out_t    out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  uart_flash_bootloader_engine dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow of the engine
  logic [7:0]  sh_version;
  logic [15:0] sh_product;
  int          sh_prot, sh_total;
  ube_phase_e  sh_phase;
  logic [7:0]  sh_cmd;
  int          sh_addr, sh_cnt, sh_sum, sh_remain, sh_stream;
  bit          sh_jump;
  logic [7:0]  sh_buf [0:BufBytes-1];
  logic [7:0]  sh_flash [0:FLASH-1];
  logic [7:0]  sh_replies [$];

  ube_out_t    tx_expected [$];
  int          n_errors, n_items, n_results, n_jumps, n_writes;
  int          burst_left, hold_req;

  function automatic void reply(logic [7:0] b);
    if (sh_replies.size() < QDepth) sh_replies.push_back(b);
  endfunction

  function automatic void refuse();
    reply(NackByte);
    sh_phase = PhIdle;
  endfunction

  function automatic void wipe_page(int p);
    if (p >= sh_total || p >= FLASH / PAGE) return;
    for (int i = 0; i < PAGE && p * PAGE + i < FLASH; i++) sh_flash[p * PAGE + i] = ByteFf;
  endfunction

  function automatic bit is_known(logic [7:0] c);
    return c == CmdGet || c == CmdGetVer || c == CmdGetId || c == CmdRead ||
           c == CmdGo || c == CmdWrite || c == CmdErase;
  endfunction

  function automatic void launch();
    reply(AckByte);
    sh_phase = PhIdle;
    case (sh_cmd)
      CmdGet: begin
        reply(GetCount); reply(sh_version);
        reply(CmdGet); reply(CmdGetVer); reply(CmdGetId); reply(CmdRead);
        reply(CmdGo); reply(CmdWrite); reply(CmdErase); reply(AckByte);
      end
      CmdGetVer: begin
        reply(sh_version); reply(ByteZero); reply(ByteZero); reply(AckByte);
      end
      CmdGetId: begin
        reply(8'h01); reply(sh_product[15:8]); reply(sh_product[7:0]); reply(AckByte);
      end
      CmdErase: sh_phase = PhElen;
      default: begin
        sh_phase = PhAddr;
        sh_cnt = 0;
        sh_sum = 0;
        sh_addr = 0;
      end
    endcase
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    case (sh_phase)
      PhCheck: begin
        if (b == (sh_cmd ^ ByteFf)) begin
          if (is_known(sh_cmd)) launch();
          else refuse();
        end else if (b == CmdInit) begin
          reply(AckByte);
          sh_phase = PhIdle;
        end else begin
          sh_cmd = b;
        end
      end
      PhAddr: begin
        if (sh_cnt < 4) begin
          sh_sum ^= int'(b);
          if (sh_cnt >= 2) sh_addr = ((sh_addr << 8) | int'(b)) & 16'hFFFF;
          sh_cnt++;
        end else if (int'(b) != sh_sum || sh_addr > FLASH) begin
          refuse();
        end else begin
          reply(AckByte);
          if (sh_cmd == CmdRead) begin
            sh_phase = PhRlen;
          end else if (sh_cmd == CmdGo) begin
            sh_jump = 1'b1;
            sh_phase = PhIdle;
          end else begin
            sh_phase = PhWlen;
          end
        end
      end
      PhRlen: begin
        sh_cnt = int'(b);
        sh_phase = PhRchk;
      end
      PhRchk: begin
        if (sh_cnt != int'(b ^ ByteFf)) begin
          refuse();
        end else begin
          reply(AckByte);
          sh_stream = sh_cnt + 1;
          sh_phase = PhIdle;
        end
      end
      PhWlen: begin
        sh_sum = int'(b);
        sh_remain = int'(b) + 1;
        sh_cnt = 0;
        if (sh_addr & 1) begin
          sh_addr--;
          sh_buf[0] = ByteFf;
          sh_cnt = 1;
        end
        sh_phase = PhWdata;
      end
      PhWdata, PhElist: begin
        if (sh_cnt < BufBytes) sh_buf[sh_cnt++] = b;
        sh_sum ^= int'(b);
        if (sh_remain > 0) sh_remain--;
        if (sh_remain == 0) sh_phase = (sh_phase == PhWdata) ? PhWsum : PhEsum;
      end
      PhWsum: begin
        if (int'(b) != sh_sum) begin
          refuse();
        end else begin
          if ((sh_cnt & 1) && sh_cnt < BufBytes) sh_buf[sh_cnt++] = ByteFf;
          for (int i = 0; i < sh_cnt; i++)
            if (sh_addr + i < FLASH) sh_flash[sh_addr + i] &= sh_buf[i];
          reply(AckByte);
          sh_phase = PhIdle;
        end
      end
      PhElen: begin
        sh_sum = int'(b);
        sh_cnt = 0;
        if (b == ByteFf) begin
          sh_phase = PhEfull;
        end else begin
          sh_remain = int'(b) + 1;
          sh_phase = PhElist;
        end
      end
      PhEfull: begin
        if (b != ByteZero) begin
          refuse();
        end else begin
          for (int i = sh_prot; i < sh_total; i++) wipe_page(i);
          reply(AckByte);
          sh_phase = PhIdle;
        end
      end
      PhEsum: begin
        if (int'(b) != sh_sum) begin
          refuse();
        end else begin
          for (int i = 0; i < sh_cnt && i < BufBytes; i++) wipe_page(int'(sh_buf[i]));
          reply(AckByte);
          sh_phase = PhIdle;
        end
      end
      default: begin
        if (b == CmdInit) begin
          reply(AckByte);
        end else begin
          sh_cmd = b;
          sh_phase = PhCheck;
        end
      end
    endcase
  endfunction

  // advance the shadow by one transfer and queue what the engine must send
  function automatic void predict_tx(ube_in_t it, int kind, logic [7:0] val);
    ube_out_t r;
    bit       has;
    has = 1'b0;
    r = '0;
    if (!it.func) begin
      if (sh_stream == 0 && !sh_jump) parse_byte(it.rx_byte);
    end else if (sh_replies.size() > 0) begin
      r.tx_byte = sh_replies.pop_front();
      has = 1'b1;
    end else if (sh_stream > 0) begin
      r.tx_byte = (sh_addr < FLASH) ? sh_flash[sh_addr] : ByteFf;
      sh_addr = (sh_addr + 1) & 16'hFFFF;
      sh_stream--;
      has = 1'b1;
    end else if (sh_jump) begin
      sh_jump = 1'b0;
      r.out_kind = 1'b1;
      r.jump_address = sh_addr[15:0];
      has = 1'b1;
    end
    if (kind == RowByte) tx_expected.push_back('{1'b0, val, 16'h0});
    else if (kind == RowPred && has) tx_expected.push_back(r);
  endfunction

  task automatic report(string what, int got, int want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  task automatic send(ube_in_t it, int kind = RowPred, logic [7:0] val = 8'h00);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_tx(it, kind, val);
    n_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  task automatic rx(logic [7:0] b);
    if ($urandom_range(0, 11) == 0) send('{1'b1, 8'($urandom)});
    send('{1'b0, b});
  endtask

  task automatic slots(int n);
    repeat (n) send('{1'b1, 8'($urandom)});
  endtask

  task automatic wait_drained();
    while (tx_expected.size() != 0) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegVersion:   sh_version = v[7:0];
      RegProductId: sh_product = v[15:0];
      RegProtPages: sh_prot = int'(v[5:0]);
      default:      sh_total = int'(v[5:0]);
    endcase
  endtask

  task automatic send_addr(int a, bit good);
    logic [7:0] b0, b1, c;
    b0 = 8'($urandom);
    b1 = 8'($urandom);
    c = b0 ^ b1 ^ a[15:8] ^ a[7:0];
    if (!good) c ^= 8'($urandom_range(1, 255));
    rx(b0); rx(b1); rx(a[15:8]); rx(a[7:0]); rx(c);
  endtask

  task automatic send_opcode(logic [7:0] c);
    rx(c);
    rx(c ^ ByteFf);
  endtask

  function automatic int pick_addr();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, FLASH);
      1: return FLASH - $urandom_range(0, 3);
      2: return FLASH + $urandom_range(1, 32767);
      default: return $urandom_range(0, 2047);
    endcase
  endfunction

  function automatic int pick_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(16, 255) : $urandom_range(0, 15);
  endfunction

  // one random command sequence followed by enough slots to empty the engine
  task automatic random_command();
    logic [7:0] n, s, d;
    int         a, tail;
    tail = 16;
    case ($urandom_range(0, 15))
      0: send_opcode(CmdGet);
      1: send_opcode(CmdGetVer);
      2: send_opcode(CmdGetId);
      3, 4: begin
        send_opcode(CmdRead);
        a = pick_addr();
        send_addr(a, $urandom_range(0, 7) != 0);
        n = 8'(pick_len());
        rx(n);
        rx(($urandom_range(0, 7) == 0) ? 8'($urandom) : n ^ ByteFf);
        tail += int'(n) + 1;
      end
      5: begin
        send_opcode(CmdGo);
        send_addr(pick_addr(), $urandom_range(0, 5) != 0);
        n_jumps++;
      end
      6, 7, 8: begin
        send_opcode(CmdWrite);
        send_addr(pick_addr(), $urandom_range(0, 7) != 0);
        n = 8'(pick_len());
        s = n;
        rx(n);
        for (int i = 0; i <= int'(n); i++) begin
          d = ($urandom_range(0, 3) == 0) ? ByteFf : 8'($urandom);
          s ^= d;
          rx(d);
        end
        rx(($urandom_range(0, 7) == 0) ? s ^ 8'($urandom_range(1, 255)) : s);
        n_writes++;
      end
      9, 10: begin
        send_opcode(CmdErase);
        n = 8'($urandom_range(0, 3));
        s = n;
        rx(n);
        for (int i = 0; i <= int'(n); i++) begin
          d = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
          s ^= d;
          rx(d);
        end
        rx(($urandom_range(0, 7) == 0) ? s ^ 8'($urandom_range(1, 255)) : s);
      end
      11: begin
        send_opcode(CmdErase);
        rx(ByteFf);
        rx(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : ByteZero);
      end
      12: begin
        d = 8'($urandom);
        rx(d);
        rx(($urandom_range(0, 1) == 0) ? CmdInit : 8'($urandom));
        rx(($urandom_range(0, 1) == 0) ? CmdInit : 8'($urandom));
      end
      13: begin
        do d = 8'($urandom); while (is_known(d) || d == CmdInit);
        send_opcode(d);
      end
      14: rx(CmdInit);
      default: repeat ($urandom_range(1, 6)) rx(8'($urandom));
    endcase
    slots(tail);
  endtask

  typedef struct {
    ube_in_t    it;
    int         kind;
    logic [7:0] val;
  } tx_row_t;

  tx_row_t rows [$] = '{
    '{'{1'b1, 8'h00}, RowNone, 8'h00},
    '{'{1'b0, CmdInit}, RowNone, 8'h00},
    '{'{1'b1, 8'h00}, RowByte, AckByte},
    '{'{1'b0, CmdGetVer}, RowNone, 8'h00},
    '{'{1'b0, 8'hFE}, RowNone, 8'h00},
    '{'{1'b1, 8'hFF}, RowByte, AckByte},
    '{'{1'b1, 8'h00}, RowByte, 8'h10},
    '{'{1'b1, 8'h00}, RowByte, ByteZero},
    '{'{1'b1, 8'h00}, RowByte, ByteZero},
    '{'{1'b1, 8'h00}, RowByte, AckByte},
    '{'{1'b0, CmdGetId}, RowNone, 8'h00},
    '{'{1'b0, 8'hFD}, RowNone, 8'h00},
    '{'{1'b1, 8'h00}, RowByte, AckByte},
    '{'{1'b1, 8'h00}, RowByte, 8'h01},
    '{'{1'b1, 8'h00}, RowByte, 8'h04},
    '{'{1'b1, 8'h00}, RowByte, 8'h10},
    '{'{1'b1, 8'h00}, RowByte, AckByte},
    '{'{1'b0, 8'h55}, RowNone, 8'h00},
    '{'{1'b0, 8'hAA}, RowNone, 8'h00},
    '{'{1'b1, 8'h00}, RowByte, NackByte},
    '{'{1'b0, 8'hFF}, RowPred, 8'h00},
    '{'{1'b0, 8'h00}, RowPred, 8'h00},
    '{'{1'b1, 8'h00}, RowPred, 8'h00},
    '{'{1'b1, 8'h00}, RowPred, 8'h00},
    '{'{1'b1, 8'h00}, RowPred, 8'h00}
  };

  // output checker
  always @(posedge clk_i) begin
    ube_out_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (tx_expected.size() == 0) begin
        report("unexpected transfer", int'(out_data_o), 0);
      end else begin
        w = tx_expected.pop_front();
        if (out_data_o.out_kind != w.out_kind)
          report("out_kind", int'(out_data_o.out_kind), int'(w.out_kind));
        if (out_data_o.tx_byte != w.tx_byte)
          report("tx_byte", int'(out_data_o.tx_byte), int'(w.tx_byte));
        if (out_data_o.jump_address != w.jump_address)
          report("jump_address", int'(out_data_o.jump_address), int'(w.jump_address));
      end
    end
  end

  // receiver stall pattern, with a single long hold-off
  int hold_left, stall_mode, mode_left;
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(10, 80);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_mode == 0) begin
      out_stall_i <= 1'b0;
    end else if (stall_mode == 1) begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall_i <= ($urandom_range(0, 1) == 0);
    end
  end

  int idle_cycles;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_MAX) begin
      $display("timeout: no transfer for %0d cycles", WDOG_MAX);
      $display("tb_uart_flash_bootloader_engine: errors");
      $finish;
    end
  end

  initial begin
    sh_version = 8'd16;
    sh_product = 16'd1040;
    sh_prot = 4;
    sh_total = 32;
    sh_phase = PhIdle;
    sh_cmd = '0;
    sh_addr = 0; sh_cnt = 0; sh_sum = 0; sh_remain = 0; sh_stream = 0;
    sh_jump = 1'b0;
    foreach (sh_buf[i]) sh_buf[i] = '0;
    foreach (sh_flash[i]) sh_flash[i] = ByteFf;
    n_errors = 0; n_items = 0; n_results = 0; n_jumps = 0; n_writes = 0;
    burst_left = 0; hold_req = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) send(rows[i].it, rows[i].kind, rows[i].val);
    slots(16);

    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) begin
        in_valid_i <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge clk_i);
        case (ph)
          1: begin
            reg_write(RegVersion, 32'hFF); reg_write(RegProductId, 32'hFFFF);
            reg_write(RegProtPages, 32'd0); reg_write(RegTotPages, 32'd1);
          end
          2: begin
            reg_write(RegVersion, 32'h00); reg_write(RegProductId, 32'h0000);
            reg_write(RegProtPages, 32'd32); reg_write(RegTotPages, 32'd32);
          end
          default: begin
            reg_write(RegVersion, $urandom_range(0, 255));
            reg_write(RegProductId, $urandom_range(0, 65535));
            reg_write(RegProtPages, $urandom_range(0, 32));
            reg_write(RegTotPages, $urandom_range(1, 32));
          end
        endcase
      end
      if (ph == 1) hold_req = 1;
      for (int k = n_items; n_items - k < PER_PHASE / 2; ) random_command();
      in_valid_i <= 1'b0;
      wait_drained();
      for (int k = n_items; n_items - k < PER_PHASE / 2; ) random_command();
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (50) @(posedge clk_i);
    $display("covered %0d transfers in, %0d out, %0d writes, %0d go commands",
             n_items, n_results, n_writes, n_jumps);
    $display("four register settings including extremes, with stalls and a long hold-off");
    if (n_errors == 0) begin
      $display("tb_uart_flash_bootloader_engine: clean");
    end else begin
      $display("tb_uart_flash_bootloader_engine: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* uart_flash_bootloader_engine.f */
rtl/ube_pkg.sv
rtl/ube_ram.sv
rtl/uart_flash_bootloader_engine.sv
bench/tb_uart_flash_bootloader_engine.sv
